// ===== design/svt_pkg.sv =====
// Shared types and constants for the sorted value table.
// Used by svt_cell and sorted_value_table_core; no dependencies.
package svt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_POP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic                    en;
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
    logic                    found;
    logic                    full;
    logic                    empty;
  } op_t;

endpackage

// ===== design/sorted_value_table_core.sv =====
// Sorted value table: a row of svt_cell slots kept in ascending signed order.
// The result strobe on done is registered: it rises in the cycle after the accepted item.
// Throughput: one item per cycle; every cell compares in parallel and shifts
// one place toward a neighbor, so busy never rises.
// Reset (rst, synchronous): clears the entry count; slot contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_value_table_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic signed [svt_pkg::VAL_W-1:0]  value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic                              found,
  output logic signed [svt_pkg::VAL_W-1:0]  out_value,
  output logic [svt_pkg::OUT_CNT_W-1:0]     entry_count
);

  localparam int N = svt_pkg::CAPACITY;

  logic [svt_pkg::CNT_W-1:0]        count;
  logic [svt_pkg::CNT_W-1:0]        count_next;
  logic                             accept;
  svt_pkg::op_t                     op;
  logic signed [svt_pkg::VAL_W-1:0] entries [N];
  logic [N-1:0]                     lt;
  logic [N-1:0]                     eq;
  logic [N-1:0]                     occupied;
  svt_pkg::status_t                 status_next;
  logic                             found_next;
  logic signed [svt_pkg::VAL_W-1:0] out_value_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Broadcast the command to the row
  always_comb begin
    op.en    = accept;
    op.cmd   = svt_pkg::cmd_t'(cmd);
    op.value = value;
    op.found = |eq;
    op.full  = (count == svt_pkg::CNT_W'(N));
    op.empty = (count == '0);
  end

  // Build the row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             left_lt;
    logic signed [svt_pkg::VAL_W-1:0] left_entry;
    logic signed [svt_pkg::VAL_W-1:0] right_entry;

    assign occupied[i] = (svt_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = value;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_entry = value;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    svt_cell u_cell (
      .clk         (clk),
      .op          (op),
      .occupied    (occupied[i]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .lt          (lt[i]),
      .eq          (eq[i])
    );
  end

  // Work out the result and the new count
  always_comb begin
    status_next    = svt_pkg::ST_OK;
    found_next     = 1'b0;
    out_value_next = '0;
    count_next     = count;
    case (op.cmd)
      svt_pkg::CMD_INSERT: begin
        if (op.full) begin
          status_next = svt_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      svt_pkg::CMD_FIND: begin
        if (op.found) begin
          found_next = 1'b1;
        end else begin
          status_next = svt_pkg::ST_NOT_FOUND;
        end
      end
      svt_pkg::CMD_DELETE: begin
        if (op.found) begin
          found_next = 1'b1;
          count_next = count - 1'b1;
        end else begin
          status_next = svt_pkg::ST_NOT_FOUND;
        end
      end
      svt_pkg::CMD_POP: begin
        if (op.empty) begin
          status_next = svt_pkg::ST_EMPTY;
        end else begin
          out_value_next = entries[0];
          count_next     = count - 1'b1;
        end
      end
      default: begin
        status_next = svt_pkg::ST_OK;
      end
    endcase
  end

  // Advance the count and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      found       <= found_next;
      out_value   <= out_value_next;
      entry_count <= svt_pkg::OUT_CNT_W'(count_next);
    end
  end

  // The count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= svt_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // A result follows exactly the cycle after an accepted item
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result strobe missing after accepted item");

  // Occupied slots form a prefix of the row
  a_occ_prefix: assert property (@(posedge clk) disable iff (rst)
    ((occupied >> 1) & ~occupied) == '0)
    else $error("occupied slots not contiguous");

  // Insert into a full table leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && op.cmd == svt_pkg::CMD_INSERT && op.full |=> $stable(count))
    else $error("count changed on insert into full table");

  // The less-than flags form a prefix, as the row is sorted
  a_lt_prefix: assert property (@(posedge clk) disable iff (rst)
    ((lt >> 1) & ~lt) == '0)
    else $error("row order broken");

endmodule

// ===== design/svt_cell.sv =====
// One slot of the sorted row: holds an entry, compares it with the command value
// and shifts toward a neighbor on insert, delete and pop. Depends on svt_pkg.
module svt_cell (
  input  logic                            clk,
  input  svt_pkg::op_t                    op,
  input  logic                            occupied,
  input  logic                            left_lt,
  input  logic signed [svt_pkg::VAL_W-1:0] left_entry,
  input  logic signed [svt_pkg::VAL_W-1:0] right_entry,
  output logic signed [svt_pkg::VAL_W-1:0] entry,
  output logic                            lt,
  output logic                            eq
);

  logic signed [svt_pkg::VAL_W-1:0] entry_next;

  // Compare the stored entry with the broadcast value
  assign lt = occupied && (entry < op.value);
  assign eq = occupied && (entry == op.value);

  // Pick the new content: hold, take the value, or take a neighbor
  always_comb begin
    entry_next = entry;
    if (op.en) begin
      case (op.cmd)
        svt_pkg::CMD_INSERT: begin
          if (!op.full && !lt) begin
            entry_next = left_lt ? op.value : left_entry;
          end
        end
        svt_pkg::CMD_DELETE: begin
          if (op.found && !lt) begin
            entry_next = right_entry;
          end
        end
        svt_pkg::CMD_POP: begin
          if (!op.empty) begin
            entry_next = right_entry;
          end
        end
        default: begin
          entry_next = entry;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== bench/sorted_value_table_core_tb.sv =====
// Self-checking bench for sorted_value_table_core: directed items, then biased random items.
// Each item is checked against a queue-based model of the sorted table.
// Depends on svt_pkg and sorted_value_table_core.
module sorted_value_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svt_pkg::*;

  localparam int RAND_CHUNKS = 31;
  localparam int CHUNK_LEN   = 50;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 40;
  localparam int RECENT_MAX  = 16;

  // Command mix of one random chunk
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  typedef struct {
    cmd_t                    op;
    logic signed [VAL_W-1:0] operand;
  } table_item_t;

  typedef struct {
    status_t                 status;
    logic                    hit;
    logic signed [VAL_W-1:0] popped;
    logic [OUT_CNT_W-1:0]    count;
  } table_reply_t;

  logic                    clk   = 1'b0;
  logic                    rst   = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              cmd   = CMD_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic                    found;
  logic signed [VAL_W-1:0] out_value;
  logic [OUT_CNT_W-1:0]    entry_count;

  table_item_t             pending_items[$];
  table_reply_t            replies_due[$];
  logic signed [VAL_W-1:0] held_values[$];
  logic signed [VAL_W-1:0] recent_inserts[$];

  table_item_t  drive_item;
  table_item_t  seen_item;
  table_reply_t due_reply;
  table_reply_t want_reply;
  int           idle_pct     = 10;
  bit           took         = 1'b0;
  int           errors       = 0;
  int           quiet_cycles = 0;

  sorted_value_table_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .value       (value),
    .done        (done),
    .status      (status),
    .found       (found),
    .out_value   (out_value),
    .entry_count (entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one item to the model table and work out its reply
  task automatic sort_apply(input table_item_t it, output table_reply_t rp);
    int pos;
    rp.status = ST_OK;
    rp.hit    = 1'b0;
    rp.popped = '0;
    case (it.op)
      CMD_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          rp.status = ST_FULL;
        end else begin
          // go in front of any equal entries
          pos = 0;
          while (pos < held_values.size() && held_values[pos] < it.operand) pos++;
          held_values.insert(pos, it.operand);
        end
      end
      CMD_FIND, CMD_DELETE: begin
        pos = -1;
        for (int i = 0; i < held_values.size(); i++) begin
          if (held_values[i] == it.operand) begin
            pos = i;
            break;
          end
          if (held_values[i] > it.operand) break;
        end
        if (pos < 0) begin
          rp.status = ST_NOT_FOUND;
        end else begin
          rp.hit = 1'b1;
          if (it.op == CMD_DELETE) held_values.delete(pos);
        end
      end
      default: begin
        if (held_values.size() == 0) rp.status = ST_EMPTY;
        else rp.popped = held_values.pop_front();
      end
    endcase
    rp.count = OUT_CNT_W'(held_values.size());
  endtask

  task automatic check_field(string what, logic signed [32:0] want, logic signed [32:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Queue one item for the driver; remember inserted values for later hits
  task automatic queue_item(cmd_t op, logic signed [VAL_W-1:0] v);
    table_item_t it;
    it.op      = op;
    it.operand = v;
    pending_items.push_back(it);
    if (op == CMD_INSERT) begin
      recent_inserts.push_back(v);
      if (recent_inserts.size() > RECENT_MAX) void'(recent_inserts.pop_front());
    end
  endtask

  function automatic cmd_t pick_op(mix_t mix);
    int r;
    int w_ins;
    int w_find;
    int w_del;
    case (mix)
      MIX_FILL:  begin w_ins = 60; w_find = 15; w_del = 15; end
      MIX_DRAIN: begin w_ins = 15; w_find = 15; w_del = 35; end
      default:   begin w_ins = 35; w_find = 25; w_del = 20; end
    endcase
    r = $urandom_range(99);
    if (r < w_ins) return CMD_INSERT;
    if (r < w_ins + w_find) return CMD_FIND;
    if (r < w_ins + w_find + w_del) return CMD_DELETE;
    return CMD_POP;
  endfunction

  // Favor small values and recent inserts so finds and deletes hit often
  function automatic logic signed [VAL_W-1:0] pick_value(cmd_t op);
    int r;
    r = $urandom_range(99);
    if (op != CMD_INSERT && recent_inserts.size() != 0 && r < 40)
      return recent_inserts[$urandom_range(recent_inserts.size() - 1)];
    r = $urandom_range(99);
    if (r < 45) return int'($urandom_range(8)) - 4;
    if (r < 60) begin
      case ($urandom_range(5))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sh7ffffffe;
        3:       return 32'sh80000001;
        4:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Hold until every queued item is accepted and every reply has come
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || replies_due.size() != 0 || start);
  endtask

  // Driver: present the next item at the falling edge, or idle
  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drive_item = pending_items.pop_front();
        start <= 1'b1;
        cmd   <= drive_item.op;
        value <= drive_item.operand;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: record accepted items, check each reply against the oldest one due
  always @(posedge clk) begin
    took = !rst && start && !busy;
    if (took) begin
      seen_item.op      = cmd_t'(cmd);
      seen_item.operand = value;
      sort_apply(seen_item, due_reply);
      replies_due.push_back(due_reply);
    end
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: reply expected none, got status %0d value %0d count %0d",
                   $time, status, out_value, entry_count);
      end else begin
        want_reply = replies_due.pop_front();
        check_field("status", 33'(want_reply.status), 33'(status));
        check_field("found", 33'(want_reply.hit), 33'(found));
        check_field("out_value", 33'(want_reply.popped), 33'(out_value));
        check_field("entry_count", 33'(want_reply.count), 33'(entry_count));
      end
    end
    // watchdog: cycles with neither an item nor a reply
    if (took || (!rst && done)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    mix_t mix;
    cmd_t op;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table: pop, find and delete all miss
    queue_item(CMD_POP, 32'sh12345678);
    queue_item(CMD_FIND, 0);
    queue_item(CMD_DELETE, -1);
    // extremes and duplicates
    queue_item(CMD_INSERT, 32'sh7fffffff);
    queue_item(CMD_INSERT, 32'sh80000000);
    queue_item(CMD_INSERT, 0);
    queue_item(CMD_INSERT, -1);
    queue_item(CMD_INSERT, 5);
    queue_item(CMD_INSERT, 5);
    queue_item(CMD_INSERT, 5);
    // fill to capacity, then insert into a full table
    queue_item(CMD_INSERT, -5);
    queue_item(CMD_INSERT, 3);
    queue_item(CMD_INSERT, 100);
    queue_item(CMD_INSERT, -100);
    queue_item(CMD_INSERT, 32'sh40000000);
    queue_item(CMD_INSERT, 32'shc0000000);
    queue_item(CMD_INSERT, 1);
    queue_item(CMD_INSERT, -2);
    queue_item(CMD_INSERT, 2);
    queue_item(CMD_INSERT, 4);
    // hit, miss between entries, duplicate delete, pop smallest, delete miss
    queue_item(CMD_FIND, 5);
    queue_item(CMD_FIND, 4);
    queue_item(CMD_DELETE, 5);
    queue_item(CMD_POP, 32'shffffffff);
    queue_item(CMD_DELETE, 6);
    wait_drained();

    // random chunks, each with its own command mix
    for (int c = 0; c < RAND_CHUNKS; c++) begin
      mix      = mix_t'($urandom_range(2));
      idle_pct = (c >= 10 && c < 14) ? 0 : 10;
      for (int k = 0; k < CHUNK_LEN; k++) begin
        op = pick_op(mix);
        if (op == CMD_POP) queue_item(op, $urandom);
        else queue_item(op, pick_value(op));
      end
      if (c % 8 == 7) begin
        wait_drained();
      end else begin
        while (pending_items.size() > 4) @(posedge clk);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
